/* src/qesm_pkg.sv */
// Shared types and constants for the quadrature encoder speed meter.
package qesm_pkg;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int SCALE_W   = 32;
  localparam int DIV_CNT_W = $clog2(SCALE_W);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd1000000;
  localparam logic [31:0]        SPEED_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0]        SPEED_NEG_MAX = 32'h8000_0000;

  typedef enum logic {
    CMD_EDGE  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic        a_level;
    logic        b_level;
    logic [31:0] now_us;
  } in_t;

  typedef struct packed {
    logic signed [31:0] position_count;
    logic               moving_forward;
    logic               reversed;
    logic [31:0]        period_us;
    logic signed [31:0] speed;
    logic               speed_saturated;
  } out_t;

  typedef struct packed {
    logic accept;
    logic start_div;
    logic div_step;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic div_needed;
    logic div_last;
  } status_t;

endpackage

/* src/qesm_ctrl.sv */
// Controller state machine that sequences acceptance, division and result loading.
module qesm_ctrl
  import qesm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    ctrl_o           = '0;
    in_ready_o       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          if (status_i.div_needed) begin
            ctrl_o.start_div = 1'b1;
            state_d          = ST_DIVIDE;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_DIVIDE: begin
        ctrl_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.load_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = ctrl_o.load_out | (out_valid_q & ~out_ready_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/qesm_datapath.sv */
// Datapath: encoder state, configuration, period selection, divider and output register.
module qesm_datapath
  import qesm_pkg::*;
#(
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_data_i,
  input  in_t                  in_i,
  input  ctrl_t                ctrl_i,
  output status_t              status_o,
  output out_t                 out_o
);

  logic                   invert_q;
  logic [SCALE_W-1:0]     scale_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic                   dir_up_q;
  logic                   rev_q;
  logic [TIME_WIDTH-1:0]  last_t_q;
  logic [TIME_WIDTH-1:0]  prior_t_q;

  logic [TIME_WIDTH-1:0]  now_t;
  logic [TIME_WIDTH-1:0]  interval;
  logic [TIME_WIDTH-1:0]  since;
  logic [TIME_WIDTH-1:0]  period;
  logic                   up;

  logic [TIME_WIDTH-1:0]  period_q;
  logic [TIME_WIDTH-1:0]  rem_q;
  logic [SCALE_W-1:0]     quo_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic                   divided_q;
  logic [31:0]            res_speed_q;
  logic                   res_sat_q;
  out_t                   out_q;

  logic [TIME_WIDTH:0]    trial;
  logic                   fits;
  logic [31:0]            fin_speed;
  logic                   fin_sat;

  assign now_t    = TIME_WIDTH'(in_i.now_us);
  assign interval = last_t_q - prior_t_q;
  assign since    = now_t - last_t_q;
  assign period   = (interval > since) ? interval : since;
  assign up       = in_i.a_level ^ in_i.b_level ^ invert_q;

  assign status_o.div_needed = (in_i.cmd == CMD_QUERY) && !rev_q && (period != '0);
  assign status_o.div_last   = (cnt_q == DIV_CNT_W'(SCALE_W - 1));

  assign trial = {rem_q, quo_q[SCALE_W-1]};
  assign fits  = trial >= {1'b0, period_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q  <= 1'b0;
      scale_q   <= SCALE_RESET;
      count_q   <= '0;
      dir_up_q  <= 1'b1;
      rev_q     <= 1'b0;
      last_t_q  <= '0;
      prior_t_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INVERT: invert_q <= cfg_data_i[0];
          CFG_SCALE:  scale_q  <= cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (ctrl_i.accept && in_i.cmd == CMD_EDGE) begin
        prior_t_q <= last_t_q;
        last_t_q  <= now_t;
        count_q   <= up ? count_q + 1'b1 : count_q - 1'b1;
        rev_q     <= (up != dir_up_q);
        dir_up_q  <= up;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      divided_q <= ctrl_i.start_div;
      if (in_i.cmd == CMD_EDGE) begin
        period_q    <= '0;
        res_speed_q <= '0;
        res_sat_q   <= 1'b0;
      end else begin
        period_q <= period;
        if (!rev_q && period == '0) begin
          res_speed_q <= dir_up_q ? SPEED_POS_MAX : SPEED_NEG_MAX;
          res_sat_q   <= 1'b1;
        end else begin
          res_speed_q <= '0;
          res_sat_q   <= 1'b0;
        end
      end
    end
    if (ctrl_i.start_div) begin
      rem_q <= '0;
      quo_q <= scale_q;
      cnt_q <= '0;
    end else if (ctrl_i.div_step) begin
      rem_q <= fits ? TIME_WIDTH'(trial - {1'b0, period_q}) : trial[TIME_WIDTH-1:0];
      quo_q <= {quo_q[SCALE_W-2:0], fits};
      cnt_q <= cnt_q + 1'b1;
    end
    if (ctrl_i.load_out) begin
      out_q <= out_d();
    end
  end

  always_comb begin
    fin_speed = res_speed_q;
    fin_sat   = res_sat_q;
    if (divided_q) begin
      if (dir_up_q) begin
        if (quo_q > SPEED_POS_MAX) begin
          fin_speed = SPEED_POS_MAX;
          fin_sat   = 1'b1;
        end else begin
          fin_speed = quo_q;
          fin_sat   = 1'b0;
        end
      end else begin
        if (quo_q > SPEED_NEG_MAX) begin
          fin_speed = SPEED_NEG_MAX;
          fin_sat   = 1'b1;
        end else begin
          fin_speed = 32'd0 - quo_q;
          fin_sat   = 1'b0;
        end
      end
    end
  end

  function automatic out_t out_d();
    out_t r;
    r.position_count  = 32'(count_q);
    r.moving_forward  = dir_up_q;
    r.reversed        = rev_q;
    r.period_us       = 32'(period_q);
    r.speed           = fin_speed;
    r.speed_saturated = fin_sat;
    return r;
  endfunction

  assign out_o = out_q;

endmodule

/* src/quadrature_encoder_speed_meter_top.sv */
// Top level of the quadrature encoder speed meter.
// Usage: one x2-decoded encoder channel. Each input transaction on in_i is either an
// A-edge event (cmd = CMD_EDGE) carrying the A and B levels and a microsecond time,
// or a speed query (cmd = CMD_QUERY) carrying the current time. Every input
// transaction yields exactly one output transaction on out_o with the position count,
// direction, reversal flag, chosen period and signed speed.
// Sequence: an edge or a query that needs no division is accepted, then loaded into the
// output register. A query that divides is accepted, then runs 32 steps of the radix-2
// restoring divider that forms speed_scale / period, then is saturated and loaded into
// the output register. One item is processed at a time, so a new input is not accepted
// until the result of the previous one has been loaded into the output register.
// Reset clears the count, the edge times and the reversal mark, sets the direction to
// forward and speed_scale to one million. Configuration writes are taken whenever
// cfg_we_i is high and must only happen while the block is idle.
// When the receiver stalls, the result waits in the output register; the next input
// is still accepted and processed, and its result is held until the register frees.
module quadrature_encoder_speed_meter_top
  import qesm_pkg::*;
#(
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_o
);

  ctrl_t   ctrl;
  status_t status;

  qesm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  qesm_datapath #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .out_o      (out_o)
  );

endmodule
